@@ sv/tbbq_pkg.sv @@
// Package with types, constants and helper functions of the thermal block baseline qualifier.
package tbbq_pkg;

  localparam int BaselineBlocks = 30;
  localparam int BlIdxW = $clog2(BaselineBlocks);
  localparam int BlCntW = $clog2(BaselineBlocks + 1);

  typedef enum logic [2:0] {
    ST_UNAVAIL  = 3'd0,
    ST_COLD     = 3'd1,
    ST_UNSTABLE = 3'd2,
    ST_BUILDING = 3'd3,
    ST_READY    = 3'd4,
    ST_DEVIATE  = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_WARM_DELTA_MIN = 1'd0,
    REG_MAX_BLOCK_STD  = 1'd1
  } reg_idx_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_SUM,
    FSM_MEAN,
    FSM_SQ,
    FSM_ACC,
    FSM_LIM,
    FSM_DECIDE,
    FSM_SEL_RD,
    FSM_SEL_CMP,
    FSM_SEL_NEXT,
    FSM_MED,
    FSM_OUT
  } fsm_e;

  function automatic logic signed [16:0] sat17(input logic signed [18:0] v);
    if (v > 19'sd65535) begin
      return 17'sd65535;
    end else if (v < -19'sd65536) begin
      return -17'sd65536;
    end
    return v[16:0];
  endfunction

endpackage

@@ sv/tbbq_rank.sv @@
// Rank counter that counts the baseline entries below a candidate with one comparator.
module tbbq_rank
  import tbbq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clr_i,
  input  logic                     cmp_en_i,
  input  logic signed [16:0]       cand_i,
  input  logic signed [16:0]       other_i,
  input  logic [BlIdxW-1:0]        cand_idx_i,
  input  logic [BlIdxW-1:0]        other_idx_i,
  output logic [BlCntW-1:0]        rank_o
);

  logic [BlCntW-1:0] rank_q, rank_d;
  logic              below;

  // Ties are broken by index so that every entry gets a distinct rank.
  assign below = (other_i < cand_i) || ((other_i == cand_i) && (other_idx_i < cand_idx_i));

  always_comb begin
    rank_d = rank_q;
    if (clr_i) begin
      rank_d = '0;
    end else if (cmp_en_i && below) begin
      rank_d = rank_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= '0;
    end else begin
      rank_q <= rank_d;
    end
  end

  assign rank_o = rank_q;

endmodule

@@ sv/thermal_block_baseline_qualifier_top.sv @@
// Top level of the thermal block baseline qualifier.
// Input words carry one temperature sample with its connect and accept flags.
// Words that are not accepted or repeat the last sample number give no result.
// Every fourth new sample closes a block, and the block gives one output word;
// a word with connected low gives one status 0 output word at once.
// A word that does not close a block and gives no output word raises no stall, and the next word may follow at once.
// A closing word raises in_stall_o and passes through the sum, mean, square, accumulate,
// limit and decide states before its output word is valid.
// The thirtieth stable block also runs the median search: every one of the 30
// entries is ranked against all 30 over the single comparator.
// The output word waits in a register while out_stall_i is high.
// No new word is taken until the output word has been delivered.
// Reset clears the counters, the block fill and the baseline; the
// registers return to 200 and 20.
module thermal_block_baseline_qualifier_top
  import tbbq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                connected_i,
  input  logic                accepted_i,
  input  logic [15:0]         sample_count_i,
  input  logic signed [16:0]  object_temp_i,
  input  logic signed [14:0]  ambient_temp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic signed [16:0]  object_mean_o,
  output logic signed [14:0]  ambient_mean_o,
  output logic signed [16:0]  target_delta_o,
  output logic                warm_ok_o,
  output logic                stable_ok_o,
  output logic signed [16:0]  deviation_o,
  output logic signed [16:0]  baseline_value_o,
  output logic [4:0]          baseline_blocks_o,
  output logic [15:0]         target_losses_o,
  output logic [15:0]         unstable_blocks_o,
  output logic [15:0]         evaluated_blocks_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [13:0]         cfg_data_i
);

  fsm_e state_q, state_d;

  logic [13:0] warm_min_q;
  logic [9:0]  max_std_q;

  logic signed [16:0] obj_mem [4];
  logic signed [16:0] bl_mem [BaselineBlocks];
  logic signed [16:0] bl_rd_q;
  logic signed [16:0] cand_q;

  logic signed [17:0] amb_sum_q;
  logic [1:0]         fill_q;
  logic [15:0]        last_num_q;
  logic [BlCntW-1:0]  bl_fill_q;
  logic               bl_ready_q;
  logic signed [16:0] median_q;
  logic [15:0]        loss_q, unst_q, eval_q;

  logic signed [18:0] osum_q;
  logic [1:0]         k_q;
  logic signed [20:0] diff_q;
  logic [41:0]        spread_q;
  logic [41:0]        lim_q;
  logic signed [16:0] omean_q;
  logic signed [14:0] amean_q;
  logic [BlIdxW-1:0]  ci_q, oi_q;
  logic signed [16:0] lo_val_q;

  logic               in_acc;
  logic               rank_clr, rank_cmp;
  logic [BlCntW-1:0]  rank;
  logic               ovalid_q;

  localparam logic [BlCntW-1:0] RankLo = BlCntW'((BaselineBlocks - 1) / 2);
  localparam logic [BlCntW-1:0] RankHi = BlCntW'(BaselineBlocks / 2);
  localparam logic [BlIdxW-1:0] LastIdx = BlIdxW'(BaselineBlocks - 1);

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != FSM_IDLE) || ovalid_q;

  logic signed [18:0] tdelta;
  logic               warm, stable;
  assign tdelta = 19'(omean_q) - 19'(amean_q);
  assign warm   = tdelta >= $signed({5'd0, warm_min_q});
  assign stable = spread_q <= lim_q;

  logic closes;
  assign closes = connected_i && accepted_i && (sample_count_i != last_num_q) &&
                  (fill_q == 2'd3);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:     if (in_acc && closes) state_d = FSM_SUM;
      FSM_SUM:      if (k_q == 2'd3) state_d = FSM_MEAN;
      FSM_MEAN:     state_d = FSM_SQ;
      FSM_SQ:       state_d = FSM_ACC;
      FSM_ACC:      state_d = (k_q == 2'd3) ? FSM_LIM : FSM_SQ;
      FSM_LIM:      state_d = FSM_DECIDE;
      FSM_DECIDE: begin
        if (warm && stable && !bl_ready_q && (bl_fill_q == BlCntW'(BaselineBlocks - 1))) begin
          state_d = FSM_SEL_RD;
        end else begin
          state_d = FSM_IDLE;
        end
      end
      FSM_SEL_RD:   state_d = FSM_SEL_CMP;
      FSM_SEL_CMP:  state_d = (oi_q == LastIdx) ? FSM_SEL_NEXT : FSM_SEL_CMP;
      FSM_SEL_NEXT: state_d = (ci_q == LastIdx) ? FSM_MED : FSM_SEL_RD;
      FSM_MED:      state_d = FSM_IDLE;
      default:      state_d = FSM_IDLE;
    endcase
  end

  assign rank_clr = (state_q == FSM_SEL_RD);
  assign rank_cmp = (state_q == FSM_SEL_CMP);

  tbbq_rank u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (rank_clr),
    .cmp_en_i    (rank_cmp),
    .cand_i      (cand_q),
    .other_i     (bl_rd_q),
    .cand_idx_i  (ci_q),
    .other_idx_i (oi_q),
    .rank_o      (rank)
  );

  // Registered memory read: one entry a cycle for the rank search.
  logic [BlIdxW-1:0] rd_addr;
  always_comb begin
    rd_addr = ci_q;
    if (state_q == FSM_SEL_CMP) begin
      rd_addr = (oi_q == LastIdx) ? oi_q : oi_q + 1'b1;
    end else if (state_q == FSM_SEL_RD) begin
      rd_addr = '0;
    end
  end

  logic bl_we;
  assign bl_we = (state_q == FSM_DECIDE) && warm && stable && !bl_ready_q &&
                 (bl_fill_q < BlCntW'(BaselineBlocks));

  always_ff @(posedge clk_i) begin
    if (bl_we) begin
      bl_mem[bl_fill_q[BlIdxW-1:0]] <= omean_q;
    end
    bl_rd_q <= bl_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && connected_i && accepted_i && (sample_count_i != last_num_q)) begin
      obj_mem[fill_q] <= object_temp_i;
    end
  end

  logic signed [20:0] sq_in;
  logic [19:0]        sq_abs;
  logic [39:0]        sq_prod;
  assign sq_in   = 21'(obj_mem[k_q]) * 21'sd4 - 21'(osum_q);
  assign sq_abs  = diff_q[20] ? 20'(-diff_q) : 20'(diff_q);
  assign sq_prod = sq_abs * sq_abs;

  always_ff @(posedge clk_i) begin
    case (state_q)
      FSM_SUM: osum_q <= (k_q == 2'd0) ? 19'(obj_mem[0]) : osum_q + 19'(obj_mem[k_q]);
      FSM_SQ:  diff_q <= sq_in;
      default: ;
    endcase
    if (state_q == FSM_MEAN) begin
      omean_q <= 17'(osum_q >>> 2);
      amean_q <= 15'(amb_sum_q >>> 2);
    end
    if (state_q == FSM_MEAN) begin
      spread_q <= '0;
    end else if (state_q == FSM_ACC) begin
      spread_q <= spread_q + 42'(sq_prod);
    end
    if (state_q == FSM_LIM) begin
      lim_q <= 42'({max_std_q, 6'd0}) * 42'(max_std_q);
    end
    if (state_q == FSM_SEL_RD) begin
      cand_q <= bl_mem[ci_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      ci_q <= '0;
      oi_q <= '0;
    end else begin
      if (state_q == FSM_IDLE || state_q == FSM_MEAN) begin
        k_q <= '0;
      end else if (state_q == FSM_SUM || state_q == FSM_ACC) begin
        k_q <= k_q + 1'b1;
      end
      if (state_q == FSM_DECIDE) begin
        ci_q <= '0;
      end else if (state_q == FSM_SEL_NEXT && ci_q != LastIdx) begin
        ci_q <= ci_q + 1'b1;
      end
      if (state_q == FSM_SEL_RD) begin
        oi_q <= '0;
      end else if (state_q == FSM_SEL_CMP && oi_q != LastIdx) begin
        oi_q <= oi_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_SEL_NEXT && rank == RankLo) begin
      lo_val_q <= cand_q;
    end
  end

  logic signed [16:0] hi_val_q;
  always_ff @(posedge clk_i) begin
    if (state_q == FSM_SEL_NEXT && rank == RankHi) begin
      hi_val_q <= cand_q;
    end
  end

  logic signed [17:0] med_sum;
  assign med_sum = 18'(lo_val_q) + 18'(hi_val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_IDLE;
      warm_min_q <= 14'd200;
      max_std_q  <= 10'd20;
      amb_sum_q  <= '0;
      fill_q     <= '0;
      last_num_q <= '0;
      bl_fill_q  <= '0;
      bl_ready_q <= 1'b0;
      median_q   <= '0;
      loss_q     <= '0;
      unst_q     <= '0;
      eval_q     <= '0;
      ovalid_q   <= 1'b0;
      status_o   <= '0;
      object_mean_o <= '0;
      ambient_mean_o <= '0;
      target_delta_o <= '0;
      warm_ok_o <= 1'b0;
      stable_ok_o <= 1'b0;
      deviation_o <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WARM_DELTA_MIN: warm_min_q <= cfg_data_i;
          REG_MAX_BLOCK_STD:  max_std_q <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      if (in_acc) begin
        if (!connected_i) begin
          fill_q <= '0;
          amb_sum_q <= '0;
          bl_fill_q <= '0;
          bl_ready_q <= 1'b0;
          median_q <= '0;
          ovalid_q <= 1'b1;
          status_o <= ST_UNAVAIL;
          object_mean_o <= '0;
          ambient_mean_o <= '0;
          target_delta_o <= '0;
          warm_ok_o <= 1'b0;
          stable_ok_o <= 1'b0;
          deviation_o <= '0;
        end else if (accepted_i && sample_count_i != last_num_q) begin
          last_num_q <= sample_count_i;
          amb_sum_q <= ((fill_q == 2'd0) ? 18'sd0 : amb_sum_q) + 18'(ambient_temp_i);
          fill_q <= fill_q + 1'b1;
        end
      end
      if (state_q == FSM_DECIDE) begin
        object_mean_o <= omean_q;
        ambient_mean_o <= amean_q;
        target_delta_o <= sat17(tdelta);
        warm_ok_o <= warm;
        stable_ok_o <= stable;
        if (!warm) begin
          loss_q <= (loss_q == 16'hFFFF) ? loss_q : loss_q + 1'b1;
          bl_fill_q <= '0;
          bl_ready_q <= 1'b0;
          median_q <= '0;
          status_o <= ST_COLD;
          deviation_o <= '0;
          ovalid_q <= 1'b1;
        end else if (!stable) begin
          unst_q <= (unst_q == 16'hFFFF) ? unst_q : unst_q + 1'b1;
          status_o <= ST_UNSTABLE;
          deviation_o <= '0;
          ovalid_q <= 1'b1;
        end else if (!bl_ready_q) begin
          status_o <= ST_BUILDING;
          deviation_o <= '0;
          if (bl_fill_q < BlCntW'(BaselineBlocks)) begin
            bl_fill_q <= bl_fill_q + 1'b1;
          end
          if (bl_fill_q != BlCntW'(BaselineBlocks - 1)) begin
            ovalid_q <= 1'b1;
          end
        end else begin
          eval_q <= (eval_q == 16'hFFFF) ? eval_q : eval_q + 1'b1;
          deviation_o <= sat17(19'(omean_q) - 19'(median_q));
          status_o <= ST_DEVIATE;
          ovalid_q <= 1'b1;
        end
      end
      if (state_q == FSM_MED) begin
        median_q <= 17'(med_sum >>> 1);
        bl_ready_q <= 1'b1;
        status_o <= ST_READY;
        ovalid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o        = ovalid_q;
  assign baseline_value_o   = bl_ready_q ? median_q : 17'sd0;
  assign baseline_blocks_o  = 5'(bl_fill_q);
  assign target_losses_o    = loss_q;
  assign unstable_blocks_o  = unst_q;
  assign evaluated_blocks_o = eval_q;

`ifndef SYNTH
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != FSM_IDLE) |-> in_stall_o) else $error("busy without stall");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("output word dropped");
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_fill_q <= BlCntW'(BaselineBlocks)) else $error("baseline overfill");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_ready_q |-> (bl_fill_q == BlCntW'(BaselineBlocks))) else $error("ready not full");
`endif

endmodule
